>>> src/rtbs_pkg.sv
package rtbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 11;
  localparam int ID_W        = 64;
  localparam int BLK_W       = 32;

  localparam int IN_TDATA_W  = 272;
  localparam int OUT_TDATA_W = 208;

  localparam logic [1:0] ACT_WRITE  = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_WRITTEN = 2'd2;

  typedef struct packed {
    logic [BLK_W-1:0] size;
    logic [BLK_W-1:0] offset;
    logic [ID_W-1:0]  max_id;
    logic [ID_W-1:0]  min_id;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           wdata;
  } mem_wr_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] index;
    entry_t           entry;
  } result_t;

endpackage

>>> src/range_table_binary_search.sv
// Range table of 1024 entries (min id, max id, block offset, block size) with
// binary-search lookup. Input beat tuser selects the action: write entry, lookup
// by key, or read by index. Every input beat yields exactly one output beat whose
// tuser carries the status. A write goes straight to its result, a read makes one
// table read, and a lookup one probe per search step, at most 11 probes for 1024
// entries: each probe is one registered read of the dual-port table followed by the
// 64-bit key compare. Input is held off from acceptance until the result is
// handed to the output register. entry_count may only be written while idle;
// entries must be written before a lookup or read touches them.
module range_table_binary_search (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rtbs_pkg::CNT_W-1:0]      cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // entry_index, search_key, new_min_id, new_max_id, new_block_offset,
  // new_block_size, zero pad
  input  logic [rtbs_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // action
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // found_min_id, found_max_id, found_offset, found_size, found_index, zero pad
  output logic [rtbs_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // status
  output logic [1:0]                      m_axis_tuser
);
  import rtbs_pkg::*;

  logic [CNT_W-1:0] entry_count_q;
  logic [IDX_W-1:0] in_index;
  logic [ID_W-1:0]  in_key;
  entry_t           in_entry;
  mem_wr_t          mem_wr;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  logic             out_valid_q;
  result_t          out_q;

  assign in_index        = s_axis_tdata[9:0];
  assign in_key          = s_axis_tdata[73:10];
  assign in_entry.min_id = s_axis_tdata[137:74];
  assign in_entry.max_id = s_axis_tdata[201:138];
  assign in_entry.offset = s_axis_tdata[233:202];
  assign in_entry.size   = s_axis_tdata[265:234];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_wdata_i;
    end
  end

  rtbs_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_action_i   (s_axis_tuser),
    .in_index_i    (in_index),
    .in_key_i      (in_key),
    .in_entry_i    (in_entry),
    .entry_count_i (entry_count_q),
    .mem_wr_o      (mem_wr),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  rtbs_mem u_mem (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {(OUT_TDATA_W - IDX_W - $bits(entry_t))'(0), out_q.index,
                          out_q.entry};

endmodule

>>> src/rtbs_mem.sv
module rtbs_mem (
  input  logic                     clk_i,
  input  rtbs_pkg::mem_wr_t        wr_i,
  input  logic [rtbs_pkg::IDX_W-1:0] raddr_i,
  output rtbs_pkg::entry_t         rdata_o
);
  import rtbs_pkg::*;

  entry_t mem_q [TABLE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.wdata;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/rtbs_seq.sv
module rtbs_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   in_action_i,
  input  logic [rtbs_pkg::IDX_W-1:0]   in_index_i,
  input  logic [rtbs_pkg::ID_W-1:0]    in_key_i,
  input  rtbs_pkg::entry_t             in_entry_i,
  input  logic [rtbs_pkg::CNT_W-1:0]   entry_count_i,
  output rtbs_pkg::mem_wr_t            mem_wr_o,
  output logic [rtbs_pkg::IDX_W-1:0]   mem_raddr_o,
  input  rtbs_pkg::entry_t             mem_rdata_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output rtbs_pkg::result_t            res_o
);
  import rtbs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state_q, state_d;
  logic             is_read_q, is_read_d;
  logic [CNT_W-1:0] low_q, low_d;
  logic [IDX_W-1:0] high_q, high_d;
  logic [IDX_W-1:0] mid_q, mid_d;
  logic [ID_W-1:0]  key_q, key_d;
  result_t          res_q, res_d;

  logic [CNT_W-1:0] cnt_clamp;
  logic [CNT_W-1:0] span;
  logic [IDX_W-1:0] mid_calc;
  logic             key_lt_min;
  logic             key_gt_max;
  result_t          miss_res;
  result_t          hit_res;

  assign cnt_clamp = (entry_count_i > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                           : entry_count_i;
  assign span      = {1'b0, high_q} - low_q;
  assign mid_calc  = IDX_W'(low_q + (span >> 1));

  // shared probe compare
  assign key_lt_min = key_q < mem_rdata_i.min_id;
  assign key_gt_max = key_q > mem_rdata_i.max_id;

  assign miss_res = '{status: ST_MISS, index: '0, entry: '0};
  assign hit_res  = '{status: ST_FOUND, index: mid_q, entry: mem_rdata_i};

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;
  assign mem_raddr_o = is_read_q ? mid_q : mid_calc;

  always_comb begin
    mem_wr_o.we    = in_valid_i && in_ready_o && (in_action_i == ACT_WRITE);
    mem_wr_o.addr  = in_index_i;
    mem_wr_o.wdata = in_entry_i;
  end

  always_comb begin
    state_d   = state_q;
    is_read_d = is_read_q;
    low_d     = low_q;
    high_d    = high_q;
    mid_d     = mid_q;
    key_d     = key_q;
    res_d     = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          key_d = in_key_i;
          unique case (in_action_i)
            ACT_WRITE: begin
              res_d   = '{status: ST_WRITTEN, index: '0, entry: '0};
              state_d = S_DONE;
            end
            ACT_READ: begin
              is_read_d = 1'b1;
              mid_d     = in_index_i;
              state_d   = S_READ;
            end
            ACT_LOOKUP: begin
              if (cnt_clamp == '0) begin
                res_d   = miss_res;
                state_d = S_DONE;
              end else begin
                is_read_d = 1'b0;
                low_d     = '0;
                high_d    = IDX_W'(cnt_clamp - CNT_W'(1));
                state_d   = S_READ;
              end
            end
            default: begin
              res_d   = miss_res;
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        if (!is_read_q) begin
          mid_d = mid_calc;
        end
        state_d = S_CMP;
      end
      S_CMP: begin
        if (is_read_q) begin
          res_d   = hit_res;
          state_d = S_DONE;
        end else if (key_lt_min) begin
          if ({1'b0, mid_q} > low_q) begin
            high_d  = mid_q - IDX_W'(1);
            state_d = S_READ;
          end else begin
            // also covers wrap below position zero
            res_d   = miss_res;
            state_d = S_DONE;
          end
        end else if (key_gt_max) begin
          if (mid_q < high_q) begin
            low_d   = {1'b0, mid_q} + CNT_W'(1);
            state_d = S_READ;
          end else begin
            res_d   = miss_res;
            state_d = S_DONE;
          end
        end else begin
          res_d   = hit_res;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      is_read_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      is_read_q <= is_read_d;
    end
  end

  always_ff @(posedge clk_i) begin
    low_q  <= low_d;
    high_q <= high_d;
    mid_q  <= mid_d;
    key_q  <= key_d;
    res_q  <= res_d;
  end

endmodule

>>> src/rtbs_checker.sv
module rtbs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [rtbs_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [1:0]                        m_axis_tuser
);
  import rtbs_pkg::*;

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // one item at a time: busy right after an accepted beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  // a new result only follows a busy cycle
  a_res_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without preceding work");

  // non-returning beats carry zero data
  a_zero_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_FOUND) |-> (m_axis_tdata == '0))
    else $error("miss or write beat with nonzero data");

endmodule

bind range_table_binary_search rtbs_checker u_rtbs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
